@@ rtl/ifsyu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the IMU frame sync and yaw unwrap block.
// No dependencies; used by every module in rtl/ except ifsyu_checker.
package ifsyu_pkg;

    // Frame geometry
    localparam int unsigned FRAME_LEN = 11;
    localparam int unsigned SUM_LEN   = FRAME_LEN - 1;

    typedef logic [7:0]  t_byte;
    typedef logic [3:0]  t_fill;
    typedef logic [15:0] t_yaw;
    typedef logic signed [15:0] t_turns;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SYNC_BYTE  = 1'b0;
    localparam t_cfg_idx CFG_ANGLE_TYPE = 1'b1;

    // Register reset values
    localparam t_byte SYNC_BYTE_RST  = 8'h55;
    localparam t_byte ANGLE_TYPE_RST = 8'h53;

    // Unwrap thresholds: 90 and 270 degrees in raw units of 180/32768 deg
    localparam t_yaw YAW_LOW_LIM  = 16'd16384;
    localparam t_yaw YAW_HIGH_LIM = 16'd49152;

    localparam t_turns TURNS_MAX = 16'sh7FFF;
    localparam t_turns TURNS_MIN = 16'sh8000;

    // Control state
    typedef enum logic [1:0] {
        ST_FILL = 2'b01,
        ST_EVAL = 2'b10
    } t_state;

    // Per-cell control: load the incoming word, or take the upper neighbor's byte
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

endpackage

@@ rtl/ifsyu_cell.sv @@
`timescale 1ns / 1ps
// One byte cell of the frame buffer chain.
// Depends on ifsyu_pkg (t_byte, t_cell_ctrl).
module ifsyu_cell (
    input  logic                   i_clk,
    input  ifsyu_pkg::t_cell_ctrl  i_ctrl,
    input  ifsyu_pkg::t_byte       i_load_byte,
    input  ifsyu_pkg::t_byte       i_next_byte,
    output ifsyu_pkg::t_byte       o_byte
);

    ifsyu_pkg::t_byte r_byte;
    ifsyu_pkg::t_byte n_byte;

    // shift toward cell 0 during realignment, else load when addressed
    always_comb begin
        n_byte = r_byte;
        if (i_ctrl.shift) begin
            n_byte = i_next_byte;
        end else if (i_ctrl.load) begin
            n_byte = i_load_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

@@ rtl/ifsyu_unwrap.sv @@
`timescale 1ns / 1ps
// Yaw unwrap (turn counter with saturation) and the result output register.
// Depends on ifsyu_pkg.
module ifsyu_unwrap (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  ifsyu_pkg::t_yaw       i_raw,
    output logic                  o_slot_free,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [15:0]           o_out_yaw_raw,
    output logic signed [15:0]    o_out_turn_count,
    output logic signed [31:0]    o_out_yaw_total
);

    ifsyu_pkg::t_yaw   r_prev;
    ifsyu_pkg::t_turns r_turns;
    ifsyu_pkg::t_turns n_turns;
    logic              r_valid;
    ifsyu_pkg::t_yaw   r_raw;
    ifsyu_pkg::t_turns r_turn_out;
    logic              dec;
    logic              inc;

    // wrap detection across the 0/360 boundary
    assign dec = (r_prev < ifsyu_pkg::YAW_LOW_LIM) && (i_raw > ifsyu_pkg::YAW_HIGH_LIM);
    assign inc = (r_prev > ifsyu_pkg::YAW_HIGH_LIM) && (i_raw < ifsyu_pkg::YAW_LOW_LIM);

    always_comb begin
        n_turns = r_turns;
        if (dec) begin
            if (r_turns != ifsyu_pkg::TURNS_MIN) begin
                n_turns = r_turns - 16'sd1;
            end
        end else if (inc) begin
            if (r_turns != ifsyu_pkg::TURNS_MAX) begin
                n_turns = r_turns + 16'sd1;
            end
        end
    end

    // unwrap state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_turns <= '0;
        end else if (i_fire) begin
            r_prev  <= i_raw;
            r_turns <= n_turns;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_raw      <= i_raw;
            r_turn_out <= n_turns;
        end
    end

    assign o_slot_free      = !r_valid || i_out_ready;
    assign o_out_valid      = r_valid;
    assign o_out_yaw_raw    = r_raw;
    assign o_out_turn_count = r_turn_out;
    assign o_out_yaw_total  = {r_turn_out, r_raw};

endmodule

@@ rtl/imu_frame_sync_yaw_unwrap_core.sv @@
`timescale 1ns / 1ps
// Top level: serial IMU frame synchronizer with yaw unwrap.
// Depends on ifsyu_pkg, ifsyu_cell, ifsyu_unwrap.
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_rx_byte) takes one received byte
//   per word. Bytes fill an 11-cell buffer chain at one word per cycle while
//   o_in_ready is high; the 11th byte starts an evaluation during which it is low:
//     - aligned frame (sync at cell 0, or locked): accepted, or dropped if bad
//     - lock lost on a bad checksum: lock cleared, then evaluated unlocked
//     - realignment: the chain shifts one byte toward cell 0 per cycle until
//       the sync byte reaches cell 0 or the buffer empties
//   Output channel (o_out_valid / i_out_ready) carries one result per good
//   angle frame, registered: it appears the cycle after evaluation ends.
//   A waiting result does not stop byte intake; only an evaluation that has a
//   new result to emit waits while the output register is still occupied.
//   Reset (i_rst_n low, synchronous) empties the buffer, clears lock, turn
//   count and previous yaw, and restores sync byte 0x55 and angle type 0x53.
//   Configuration writes (i_cfg_we) take effect at the clock edge.
module imu_frame_sync_yaw_unwrap_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [15:0]          o_out_yaw_raw,
    output logic signed [15:0]   o_out_turn_count,
    output logic signed [31:0]   o_out_yaw_total,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    ifsyu_pkg::t_state     r_state;
    ifsyu_pkg::t_state     n_state;
    ifsyu_pkg::t_fill      r_fill;
    ifsyu_pkg::t_fill      n_fill;
    ifsyu_pkg::t_byte      r_sum;
    ifsyu_pkg::t_byte      n_sum;
    logic                  r_locked;
    logic                  n_locked;
    ifsyu_pkg::t_byte      r_sync_byte;
    ifsyu_pkg::t_byte      r_angle_type;

    ifsyu_pkg::t_byte      cell_q [ifsyu_pkg::FRAME_LEN];
    ifsyu_pkg::t_cell_ctrl cell_ctrl [ifsyu_pkg::FRAME_LEN];

    logic in_fire;
    logic shift_en;
    logic full;
    logic sum_ok;
    logic sync0;
    logic is_angle;
    logic frame_good;
    logic slot_free;
    logic accept_go;
    logic emit;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte  <= ifsyu_pkg::SYNC_BYTE_RST;
            r_angle_type <= ifsyu_pkg::ANGLE_TYPE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ifsyu_pkg::CFG_SYNC_BYTE:  r_sync_byte  <= i_cfg_data;
                ifsyu_pkg::CFG_ANGLE_TYPE: r_angle_type <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = (r_state == ifsyu_pkg::ST_FILL);
    assign in_fire    = i_in_valid && o_in_ready;

    // buffer cell chain
    for (genvar gi = 0; gi < ifsyu_pkg::FRAME_LEN; gi++) begin : g_cell
        ifsyu_pkg::t_byte next_byte;
        if (gi == ifsyu_pkg::FRAME_LEN - 1) begin : g_last
            assign next_byte = '0;
        end else begin : g_mid
            assign next_byte = cell_q[gi + 1];
        end
        assign cell_ctrl[gi].load  = in_fire && (r_fill == 4'(gi));
        assign cell_ctrl[gi].shift = shift_en;
        ifsyu_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (cell_ctrl[gi]),
            .i_load_byte (i_rx_byte),
            .i_next_byte (next_byte),
            .o_byte      (cell_q[gi])
        );
    end

    // frame checks; r_sum tracks the wrapping sum of cells 0..9 as filled
    assign full       = (r_fill == 4'(ifsyu_pkg::FRAME_LEN));
    assign sum_ok     = (r_sum == cell_q[ifsyu_pkg::FRAME_LEN - 1]);
    assign sync0      = (cell_q[0] == r_sync_byte);
    assign is_angle   = (cell_q[1] == r_angle_type);
    assign frame_good = full && sum_ok && (r_locked || sync0);
    assign accept_go  = (r_state == ifsyu_pkg::ST_EVAL) && frame_good
                        && (!is_angle || slot_free);
    assign emit       = accept_go && is_angle;

    // control: fill, then evaluate / realign
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_sum    = r_sum;
        n_locked = r_locked;
        shift_en = 1'b0;
        case (r_state)
            ifsyu_pkg::ST_FILL: begin
                if (in_fire) begin
                    n_fill = r_fill + 4'd1;
                    if (r_fill < 4'(ifsyu_pkg::SUM_LEN)) begin
                        n_sum = r_sum + i_rx_byte;
                    end
                    if (r_fill == 4'(ifsyu_pkg::SUM_LEN)) begin
                        n_state = ifsyu_pkg::ST_EVAL;
                    end
                end
            end
            ifsyu_pkg::ST_EVAL: begin
                if (full && r_locked && !sum_ok) begin
                    // lock lost: same buffer again, unlocked
                    n_locked = 1'b0;
                end else if (frame_good) begin
                    if (accept_go) begin
                        n_locked = 1'b1;
                        n_fill   = '0;
                        n_sum    = '0;
                        n_state  = ifsyu_pkg::ST_FILL;
                    end
                end else if (sync0) begin
                    // aligned: bad frame dropped when full, else keep tail
                    if (full) begin
                        n_fill = '0;
                        n_sum  = '0;
                    end
                    n_state = ifsyu_pkg::ST_FILL;
                end else begin
                    // realign by one byte
                    shift_en = 1'b1;
                    n_fill   = r_fill - 4'd1;
                    n_sum    = r_sum - cell_q[0]
                               + (full ? cell_q[ifsyu_pkg::FRAME_LEN - 1] : 8'd0);
                    if (r_fill == 4'd1) begin
                        n_state = ifsyu_pkg::ST_FILL;
                    end
                end
            end
            default: begin
                n_state = ifsyu_pkg::ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ifsyu_pkg::ST_FILL;
            r_fill   <= '0;
            r_sum    <= '0;
            r_locked <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_sum    <= n_sum;
            r_locked <= n_locked;
        end
    end

    // yaw unwrap and result register
    ifsyu_unwrap u_unwrap (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (emit),
        .i_raw            ({cell_q[7], cell_q[6]}),
        .o_slot_free      (slot_free),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_yaw_raw    (o_out_yaw_raw),
        .o_out_turn_count (o_out_turn_count),
        .o_out_yaw_total  (o_out_yaw_total)
    );

endmodule

@@ rtl/ifsyu_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for imu_frame_sync_yaw_unwrap_core, attached by bind.
// Depends only on the top-level ports.
module ifsyu_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [15:0]         o_out_yaw_raw,
    input logic signed [15:0]  o_out_turn_count,
    input logic signed [31:0]  o_out_yaw_total
);

    // a result word stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    // stalled result word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_yaw_total))
        else $error("result payload changed while stalled");

    // continuous yaw is built from turn count and raw yaw
    a_total_parts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_yaw_total[15:0] == o_out_yaw_raw)
                        && (o_out_yaw_total[31:16] == o_out_turn_count))
        else $error("yaw_total does not match turn_count and yaw_raw");

    // after reset: no result pending, byte intake open
    a_reset_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind imu_frame_sync_yaw_unwrap_core ifsyu_checker u_ifsyu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_out_yaw_raw    (o_out_yaw_raw),
    .o_out_turn_count (o_out_turn_count),
    .o_out_yaw_total  (o_out_yaw_total)
);
